>>> design/s2rm_pkg.sv
`timescale 1ns / 1ps
package s2rm_pkg;

   localparam int S2RM_MAX_ROWS = 32;
   localparam int S2RM_MAX_COLS = 32;
   localparam int S2RM_LEVELS   = 6;

   localparam int POS_W = 5;
   localparam int CSR_W = 6;
   localparam int VAL_W = 64;
   localparam int CNT_W = 12;
   localparam int LOG_W = 4;

   localparam logic [1:0] STAT_ANSWER    = 2'd0;
   localparam logic [1:0] STAT_BUILT     = 2'd1;
   localparam logic [1:0] STAT_RANGE     = 2'd2;
   localparam logic [1:0] STAT_NOT_BUILT = 2'd3;

   localparam logic REG_ROWS = 1'b0;
   localparam logic REG_COLS = 1'b1;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic                    operation;
      logic [POS_W-1:0]        row_a;
      logic [POS_W-1:0]        col_a;
      logic [POS_W-1:0]        row_b;
      logic [POS_W-1:0]        col_b;
      logic signed [VAL_W-1:0] cell_value;
      logic                    last_load;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] max_value;
      logic [1:0]              status;
   } rsp_type;

   // Floor of log2 for x >= 1, capped at lim.
   function automatic logic [LOG_W-1:0] floor_log(input logic [CNT_W-1:0] x,
                                                  input logic [LOG_W-1:0] lim);
      logic [LOG_W-1:0] k;
      k = '0;
      for (int b = 1; b < CNT_W; b++) begin
         if (x[b]) k = LOG_W'(b);
      end
      if (k > lim) k = lim;
      return k;
   endfunction

   function automatic logic signed [VAL_W-1:0] bigger(input logic signed [VAL_W-1:0] a,
                                                      input logic signed [VAL_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

endpackage

>>> design/s2rm_ram.sv
`timescale 1ns / 1ps
module s2rm_ram #(
   parameter int AW = 16,
   parameter int DW = 64
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [2**AW];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> design/sparse_table_2d_range_max_unit.sv
`timescale 1ns / 1ps
// A query passes a range check, a log step, four table reads (one a cycle) and a wait; a
// refused query goes from the check to its result. A plain load writes as it is taken and
// gives no result. Requests are taken one at a time, once the last result is placed, and later
// while a result waits on rsp_ready. A last load builds with two reads and a write per entry,
// a step per level pair, then reports. Reset (synchronous, active high) clears the control state
// and the built flag and sets both grid sizes to their maxima; the table memory is not cleared.
module sparse_table_2d_range_max_unit
   import s2rm_pkg::*;
#(
   parameter int MAX_ROWS = S2RM_MAX_ROWS,
   parameter int MAX_COLS = S2RM_MAX_COLS,
   parameter int LEVELS   = S2RM_LEVELS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   // The table address is the concatenation of level pair, row and column, so each
   // field sits on a power-of-two boundary and no address multiply is needed.
   localparam int LW   = $clog2(LEVELS);
   localparam int RW   = $clog2(MAX_ROWS);
   localparam int CW   = $clog2(MAX_COLS);
   localparam int AW   = 2 * LW + RW + CW;
   localparam int RN_W = $clog2(MAX_ROWS + 1);
   localparam int CN_W = $clog2(MAX_COLS + 1);

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_B_LVL  = 10'b0000000010,
      ST_B_RA   = 10'b0000000100,
      ST_B_RB   = 10'b0000001000,
      ST_B_WR   = 10'b0000010000,
      ST_Q_CHK  = 10'b0000100000,
      ST_Q_LOG  = 10'b0001000000,
      ST_Q_RD   = 10'b0010000000,
      ST_Q_WAIT = 10'b0100000000,
      ST_FIN    = 10'b1000000000
   } state_type;

   function automatic logic [AW-1:0] tab_addr(input logic [LW-1:0] p, input logic [LW-1:0] q,
                                              input logic [RW-1:0] r, input logic [CW-1:0] c);
      return {p, q, r, c};
   endfunction

   state_type               state_ff, state_in;
   req_type                 item_ff, item_in;
   logic [RN_W-1:0]         rows_ff, rows_in;
   logic [CN_W-1:0]         cols_ff, cols_in;
   logic                    built_ff, built_in;
   logic [LW-1:0]           p_ff, p_in, q_ff, q_in;
   logic [RW-1:0]           i_ff, i_in;
   logic [CW-1:0]           j_ff, j_in;
   logic signed [VAL_W-1:0] acc_ff, acc_in;
   logic [POS_W-1:0]        rlo_ff, rlo_in, rhi_ff, rhi_in;
   logic [POS_W-1:0]        clo_ff, clo_in, chi_ff, chi_in;
   logic [LW-1:0]           kr_ff, kr_in, kc_ff, kc_in;
   logic [RW-1:0]           r2_ff, r2_in;
   logic [CW-1:0]           c2_ff, c2_in;
   logic [1:0]              rd_idx_ff, rd_idx_in;
   logic                    rd_pend_ff, rd_pend_in;
   logic [1:0]              fin_stat_ff, fin_stat_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                    mem_we;
   logic [AW-1:0]           mem_waddr, mem_raddr;
   logic [VAL_W-1:0]        mem_wdata, mem_rdata;

   logic [LW-1:0]           top_p, top_q;
   logic [CNT_W-1:0]        csr_val, rows_x, cols_x, kr_full, kc_full;
   logic                    accept, slot_free;

   s2rm_ram #(.AW(AW), .DW(VAL_W)) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign rows_x    = CNT_W'(rows_ff);
   assign cols_x    = CNT_W'(cols_ff);
   assign top_p     = LW'(floor_log(rows_x, LOG_W'(LEVELS - 1)));
   assign top_q     = LW'(floor_log(cols_x, LOG_W'(LEVELS - 1)));
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign csr_val   = (csr_wdata == '0) ? CNT_W'(1) : CNT_W'(csr_wdata);

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      built_in     = built_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      acc_in       = acc_ff;
      rlo_in       = rlo_ff;
      rhi_in       = rhi_ff;
      clo_in       = clo_ff;
      chi_in       = chi_ff;
      kr_in        = kr_ff;
      kc_in        = kc_ff;
      r2_in        = r2_ff;
      c2_in        = c2_ff;
      rd_idx_in    = rd_idx_ff;
      rd_pend_in   = 1'b0;
      fin_stat_in  = fin_stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = tab_addr(p_ff, q_ff, i_ff, j_ff);
      mem_wdata    = mem_rdata;
      mem_raddr    = tab_addr(p_ff, q_ff, i_ff, j_ff);
      kr_full      = '0;
      kc_full      = '0;

      // Configuration writes must arrive only while idle, so they never race a build; the block does not enforce it.
      if (csr_we) begin
         unique case (csr_index)
            REG_ROWS: begin
               rows_in = (csr_val > CNT_W'(MAX_ROWS)) ? RN_W'(MAX_ROWS) : RN_W'(csr_val);
            end
            REG_COLS: begin
               cols_in = (csr_val > CNT_W'(MAX_COLS)) ? CN_W'(MAX_COLS) : CN_W'(csr_val);
            end
            default: ;
         endcase
         built_in = 1'b0;
      end

      // Reads of the table land in the next cycle; fold each into the running maximum.
      if (rd_pend_ff) acc_in = bigger(acc_ff, mem_rdata);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_in = req_data;
               if (req_data.operation == OP_LOAD) begin
                  built_in = 1'b0;
                  if (CNT_W'(req_data.row_a) < rows_x && CNT_W'(req_data.col_a) < cols_x) begin
                     mem_we    = 1'b1;
                     mem_waddr = tab_addr('0, '0, RW'(req_data.row_a), CW'(req_data.col_a));
                     mem_wdata = req_data.cell_value;
                  end
                  if (req_data.last_load) begin
                     p_in     = '0;
                     q_in     = '0;
                     state_in = ST_B_LVL;
                  end
               end else begin
                  state_in = ST_Q_CHK;
               end
            end
         end
         ST_B_LVL: begin
            // Step to the next level pair, columns first; the base level is never rebuilt.
            i_in = '0;
            j_in = '0;
            if (q_ff < top_q) begin
               q_in     = q_ff + LW'(1);
               state_in = ST_B_RA;
            end else if (p_ff < top_p) begin
               p_in     = p_ff + LW'(1);
               q_in     = '0;
               state_in = ST_B_RA;
            end else begin
               built_in    = 1'b1;
               fin_stat_in = STAT_BUILT;
               state_in    = ST_FIN;
            end
         end
         ST_B_RA: begin
            if (p_ff != '0) mem_raddr = tab_addr(p_ff - LW'(1), q_ff, i_ff, j_ff);
            else            mem_raddr = tab_addr(p_ff, q_ff - LW'(1), i_ff, j_ff);
            state_in = ST_B_RB;
         end
         ST_B_RB: begin
            acc_in = mem_rdata;
            if (p_ff != '0) begin
               mem_raddr = tab_addr(p_ff - LW'(1), q_ff,
                                    RW'(CNT_W'(i_ff) + (CNT_W'(1) << (p_ff - LW'(1)))), j_ff);
            end else begin
               mem_raddr = tab_addr(p_ff, q_ff - LW'(1), i_ff,
                                    CW'(CNT_W'(j_ff) + (CNT_W'(1) << (q_ff - LW'(1)))));
            end
            state_in = ST_B_WR;
         end
         ST_B_WR: begin
            mem_we    = 1'b1;
            mem_waddr = tab_addr(p_ff, q_ff, i_ff, j_ff);
            mem_wdata = bigger(acc_ff, mem_rdata);
            if (CNT_W'(j_ff) + CNT_W'(1) + (CNT_W'(1) << q_ff) <= cols_x) begin
               j_in     = j_ff + CW'(1);
               state_in = ST_B_RA;
            end else if (CNT_W'(i_ff) + CNT_W'(1) + (CNT_W'(1) << p_ff) <= rows_x) begin
               j_in     = '0;
               i_in     = i_ff + RW'(1);
               state_in = ST_B_RA;
            end else begin
               state_in = ST_B_LVL;
            end
         end
         ST_Q_CHK: begin
            if (!built_ff) begin
               fin_stat_in = STAT_NOT_BUILT;
               state_in    = ST_FIN;
            end else if (CNT_W'(item_ff.row_a) >= rows_x || CNT_W'(item_ff.row_b) >= rows_x ||
                         CNT_W'(item_ff.col_a) >= cols_x || CNT_W'(item_ff.col_b) >= cols_x) begin
               fin_stat_in = STAT_RANGE;
               state_in    = ST_FIN;
            end else begin
               rlo_in   = (item_ff.row_a > item_ff.row_b) ? item_ff.row_b : item_ff.row_a;
               rhi_in   = (item_ff.row_a > item_ff.row_b) ? item_ff.row_a : item_ff.row_b;
               clo_in   = (item_ff.col_a > item_ff.col_b) ? item_ff.col_b : item_ff.col_a;
               chi_in   = (item_ff.col_a > item_ff.col_b) ? item_ff.col_a : item_ff.col_b;
               state_in = ST_Q_LOG;
            end
         end
         ST_Q_LOG: begin
            kr_full   = CNT_W'(floor_log(CNT_W'(rhi_ff) - CNT_W'(rlo_ff) + CNT_W'(1),
                                         LOG_W'(LEVELS - 1)));
            kc_full   = CNT_W'(floor_log(CNT_W'(chi_ff) - CNT_W'(clo_ff) + CNT_W'(1),
                                         LOG_W'(LEVELS - 1)));
            kr_in     = LW'(kr_full);
            kc_in     = LW'(kc_full);
            r2_in     = RW'(CNT_W'(rhi_ff) + CNT_W'(1) - (CNT_W'(1) << kr_full));
            c2_in     = CW'(CNT_W'(chi_ff) + CNT_W'(1) - (CNT_W'(1) << kc_full));
            acc_in    = {1'b1, {(VAL_W - 1){1'b0}}};
            rd_idx_in = '0;
            state_in  = ST_Q_RD;
         end
         ST_Q_RD: begin
            // Four corner blocks, one read a cycle.
            mem_raddr = tab_addr(kr_ff, kc_ff,
                                 rd_idx_ff[1] ? r2_ff : RW'(rlo_ff),
                                 rd_idx_ff[0] ? c2_ff : CW'(clo_ff));
            rd_pend_in = 1'b1;
            rd_idx_in  = rd_idx_ff + 2'd1;
            if (rd_idx_ff == 2'd3) begin
               fin_stat_in = STAT_ANSWER;
               state_in    = ST_Q_WAIT;
            end
         end
         ST_Q_WAIT: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (slot_free) begin
               rsp_valid_in     = 1'b1;
               rsp_in.status    = fin_stat_ff;
               rsp_in.max_value = (fin_stat_ff == STAT_ANSWER) ? acc_ff : '0;
               state_in         = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rows_ff      <= RN_W'(MAX_ROWS < 32 ? MAX_ROWS : 32);
         cols_ff      <= CN_W'(MAX_COLS < 32 ? MAX_COLS : 32);
         built_ff     <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         built_ff     <= built_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      p_ff        <= p_in;
      q_ff        <= q_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      acc_ff      <= acc_in;
      rlo_ff      <= rlo_in;
      rhi_ff      <= rhi_in;
      clo_ff      <= clo_in;
      chi_ff      <= chi_in;
      kr_ff       <= kr_in;
      kc_ff       <= kc_in;
      r2_ff       <= r2_in;
      c2_ff       <= c2_in;
      rd_idx_ff   <= rd_idx_in;
      fin_stat_ff <= fin_stat_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A query never writes the table.
   a_no_write_in_query: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_Q_CHK || state_ff == ST_Q_LOG || state_ff == ST_Q_RD ||
       state_ff == ST_Q_WAIT) |-> !mem_we)
      else $error("table written during a query");

   // Only an answer carries a value.
   a_zero_unless_answer: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != STAT_ANSWER) |-> (rsp_ff.max_value == '0))
      else $error("non-answer result carries a value");

   // The built flag is set only at the end of the level walk.
   a_built_after_walk: assert property (@(posedge clock) disable iff (reset)
      $rose(built_ff) |-> $past(state_ff == ST_B_LVL))
      else $error("built flag set outside the build");

   // Table reads are only folded into the maximum while a query is being answered.
   a_fold_in_query: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> (state_ff == ST_Q_RD || state_ff == ST_Q_WAIT))
      else $error("stray read fold");

endmodule

>>> tb/sv/tb_sparse_table_2d_range_max_unit.sv
`timescale 1ns / 1ps
// Testbench for the rectangle maximum unit. A scoreboard keeps its own copy of the grid,
// the grid sizes and the built flag. Every answered query is predicted by scanning the whole
// rectangle, which gives the same maximum as the four overlapping table blocks.
module tb_sparse_table_2d_range_max_unit;
   import s2rm_pkg::*;

   localparam int WATCHDOG_LIMIT = 400000;
   localparam int SETTLE_CYCLES  = 40;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   rsp_type          rsp_data;
   logic             csr_we;
   logic             csr_index;
   logic [CSR_W-1:0] csr_wdata;

   sparse_table_2d_range_max_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Scoreboard copy of the block's state. A cell counts as loaded once a load inside
   // the grid has written it; the stimulus never builds over a cell that was not loaded.
   logic signed [VAL_W-1:0] grid_cells [S2RM_MAX_ROWS][S2RM_MAX_COLS];
   bit                      cell_loaded [S2RM_MAX_ROWS][S2RM_MAX_COLS];
   int                      grid_rows;
   int                      grid_cols;
   bit                      grid_built;
   rsp_type                 pending_rsp_q [$];

   int mismatches;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_len;
   int hold_seq;
   int hold_seen;
   int hold_left;
   int quiet_cycles;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // The receiver either stalls at random or, when a hold-off has been asked for,
   // keeps ready low for the whole of that stretch.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         hold_seen <= 0;
      end else if (hold_seq != hold_seen) begin
         hold_seen <= hold_seq;
         hold_left <= hold_len;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Every result transfer is compared with the oldest expected result. The watchdog
   // counts cycles in which neither channel moves a transfer.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result with nothing expected: max %0d status %0d",
                           rsp_data.max_value, rsp_data.status);
            end else begin
               want = pending_rsp_q.pop_front();
               if (rsp_data.max_value !== want.max_value || rsp_data.status !== want.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected max %0d status %0d, got max %0d status %0d",
                              want.max_value, want.status, rsp_data.max_value, rsp_data.status);
               end
            end
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // Updates the scoreboard for one accepted request and queues its result, if any.
   task automatic predict_request(input req_type item);
      rsp_type                 r;
      logic signed [VAL_W-1:0] best;
      int                      r_lo, r_hi, c_lo, c_hi;
      r.max_value = '0;
      if (item.operation == OP_LOAD) begin
         grid_built = 1'b0;
         if (item.row_a < grid_rows && item.col_a < grid_cols) begin
            grid_cells[item.row_a][item.col_a]  = item.cell_value;
            cell_loaded[item.row_a][item.col_a] = 1'b1;
         end
         if (item.last_load) begin
            grid_built = 1'b1;
            r.status   = STAT_BUILT;
            pending_rsp_q.push_back(r);
         end
      end else begin
         // An unbuilt table is reported before any corner check.
         if (!grid_built) begin
            r.status = STAT_NOT_BUILT;
         end else if (item.row_a >= grid_rows || item.row_b >= grid_rows ||
                      item.col_a >= grid_cols || item.col_b >= grid_cols) begin
            r.status = STAT_RANGE;
         end else begin
            r_lo = int'((item.row_a < item.row_b) ? item.row_a : item.row_b);
            r_hi = int'((item.row_a < item.row_b) ? item.row_b : item.row_a);
            c_lo = int'((item.col_a < item.col_b) ? item.col_a : item.col_b);
            c_hi = int'((item.col_a < item.col_b) ? item.col_b : item.col_a);
            best = grid_cells[r_lo][c_lo];
            for (int i = r_lo; i <= r_hi; i++)
               for (int j = c_lo; j <= c_hi; j++)
                  if (grid_cells[i][j] > best) best = grid_cells[i][j];
            r.max_value = best;
            r.status    = STAT_ANSWER;
         end
         pending_rsp_q.push_back(r);
      end
   endtask

   // Offers one request, with random gaps beforehand, and waits for its transfer.
   task automatic send_request(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_request(item);
   endtask

   // The sender stops until every expected result has arrived, then lets the block settle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic index, input int value);
      int v;
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= CSR_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      v = (value == 0) ? 1 : value;
      if (index == REG_ROWS) grid_rows = (v > S2RM_MAX_ROWS) ? S2RM_MAX_ROWS : v;
      else                   grid_cols = (v > S2RM_MAX_COLS) ? S2RM_MAX_COLS : v;
      grid_built = 1'b0;
   endtask

   // Sets the grid size, sometimes through a written value that the block clamps.
   task automatic set_grid_size(input int rows, input int cols);
      int rv, cv;
      wait_drained();
      rv = rows;
      cv = cols;
      if (rows == 1 && $urandom_range(1) == 1) rv = 0;
      if (rows == S2RM_MAX_ROWS && $urandom_range(1) == 1) rv = $urandom_range(63, 33);
      if (cols == 1 && $urandom_range(1) == 1) cv = 0;
      if (cols == S2RM_MAX_COLS && $urandom_range(1) == 1) cv = $urandom_range(63, 33);
      write_csr(REG_ROWS, rv);
      write_csr(REG_COLS, cv);
   endtask

   function automatic logic signed [VAL_W-1:0] pick_value();
      case ($urandom_range(5))
         0:       return {1'b0, {(VAL_W-1){1'b1}}};
         1:       return {1'b1, {(VAL_W-1){1'b0}}};
         2:       return '0;
         3:       return '1;
         4:       return VAL_W'($signed($urandom_range(40))) - 20;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic req_type load_item(input int r, input int c,
                                         input logic signed [VAL_W-1:0] v, input logic last);
      req_type it;
      it.operation  = OP_LOAD;
      it.row_a      = POS_W'(r);
      it.col_a      = POS_W'(c);
      it.row_b      = POS_W'($urandom);
      it.col_b      = POS_W'($urandom);
      it.cell_value = v;
      it.last_load  = last;
      return it;
   endfunction

   function automatic req_type query_item(input int ra, input int ca, input int rb, input int cb);
      req_type it;
      it.operation  = OP_QUERY;
      it.row_a      = POS_W'(ra);
      it.col_a      = POS_W'(ca);
      it.row_b      = POS_W'(rb);
      it.col_b      = POS_W'(cb);
      it.cell_value = {$urandom, $urandom};
      it.last_load  = 1'($urandom_range(1));
      return it;
   endfunction

   // Loads every cell not yet loaded, rewrites some of the others, and ends with a last
   // load whose cell may lie outside the grid.
   task automatic load_and_build(input int rewrite_pct);
      for (int i = 0; i < grid_rows; i++)
         for (int j = 0; j < grid_cols; j++)
            if (!cell_loaded[i][j] || $urandom_range(99) < rewrite_pct)
               send_request(load_item(i, j, pick_value(), 1'b0));
      if ($urandom_range(3) == 0)
         send_request(load_item($urandom_range(31), $urandom_range(31), pick_value(), 1'b1));
      else
         send_request(load_item($urandom_range(grid_rows - 1), $urandom_range(grid_cols - 1),
                                pick_value(), 1'b1));
   endtask

   task automatic send_random_query();
      int ra, ca, rb, cb;
      ra = $urandom_range(grid_rows - 1);
      rb = $urandom_range(grid_rows - 1);
      ca = $urandom_range(grid_cols - 1);
      cb = $urandom_range(grid_cols - 1);
      send_request(query_item(ra, ca, rb, cb));
   endtask

   // A corner is pushed outside the grid where the grid leaves room for it.
   task automatic send_outside_query();
      int ra, ca, rb, cb;
      ra = $urandom_range(grid_rows - 1);
      rb = $urandom_range(grid_rows - 1);
      ca = $urandom_range(grid_cols - 1);
      cb = $urandom_range(grid_cols - 1);
      case ($urandom_range(3))
         0: if (grid_rows < 32) ra = $urandom_range(31, grid_rows);
         1: if (grid_rows < 32) rb = $urandom_range(31, grid_rows);
         2: if (grid_cols < 32) ca = $urandom_range(31, grid_cols);
         default: if (grid_cols < 32) cb = $urandom_range(31, grid_cols);
      endcase
      send_request(query_item(ra, ca, rb, cb));
   endtask

   task automatic test_directed();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      // A query straight after reset finds no table.
      send_request(query_item(0, 0, 31, 31));
      set_grid_size(2, 3);
      send_request(load_item(0, 0, {1'b0, {(VAL_W-1){1'b1}}}, 1'b0));
      send_request(load_item(0, 1, {1'b1, {(VAL_W-1){1'b0}}}, 1'b0));
      send_request(load_item(0, 2, '0, 1'b0));
      send_request(load_item(1, 0, '1, 1'b0));
      send_request(load_item(1, 1, 64'sd5, 1'b0));
      send_request(load_item(1, 2, {1'b1, {(VAL_W-2){1'b0}}, 1'b1}, 1'b0));
      // A load outside the grid writes nothing.
      send_request(load_item(2, 0, 64'sd99, 1'b0));
      send_request(query_item(0, 0, 1, 2));
      // The last load may name a cell outside the grid and still builds.
      send_request(load_item(31, 31, 64'sd77, 1'b1));
      send_request(query_item(0, 0, 1, 2));
      send_request(query_item(1, 2, 0, 0));
      send_request(query_item(1, 1, 1, 1));
      send_request(query_item(0, 2, 1, 1));
      send_request(query_item(1, 0, 1, 2));
      send_request(query_item(2, 0, 0, 0));
      send_request(query_item(0, 3, 0, 0));
      send_request(query_item(31, 31, 31, 31));
      // A plain load after a build leaves the table unbuilt until the next last load.
      send_request(load_item(0, 0, -64'sd3, 1'b0));
      send_request(query_item(0, 0, 0, 0));
      send_request(load_item(1, 1, 64'sd100, 1'b1));
      send_request(query_item(1, 2, 0, 0));
      // Any register write also clears the built flag.
      wait_drained();
      write_csr(REG_COLS, 3);
      send_request(query_item(0, 0, 0, 0));
   endtask

   task automatic test_single_row();
      set_grid_size(1, 32);
      load_and_build(0);
      send_request(query_item(0, 0, 0, 31));
      send_request(query_item(0, 31, 0, 0));
      for (int k = 0; k < 8; k++) send_random_query();
      send_outside_query();
   endtask

   // All rows in use, so the row levels reach the top of the table.
   task automatic test_tall_grid();
      set_grid_size(32, 4);
      load_and_build(10);
      send_request(query_item(0, 0, 31, 3));
      send_request(query_item(31, 3, 0, 0));
      send_request(query_item(31, 0, 0, 3));
      for (int k = 0; k < 12; k++) send_random_query();
   endtask

   // The receiver holds off while queries keep coming, so the block must stall its input.
   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      set_grid_size(4, 4);
      load_and_build(50);
      wait_drained();
      hold_len = 300;
      hold_seq = hold_seq + 1;
      for (int k = 0; k < 30; k++) send_random_query();
      wait_drained();
   endtask

   task automatic test_random();
      int rows, cols, n;
      for (int ph = 0; ph < 10; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
            default: begin send_idle_pct = 21; recv_stall_pct = 21; end
         endcase
         rows = $urandom_range(6, 1);
         cols = $urandom_range(6, 1);
         if (ph % 7 == 3) rows = 32;
         if (ph % 7 == 5) cols = 32;
         if (ph % 9 == 4) begin rows = 1; cols = 1; end
         set_grid_size(rows, cols);
         load_and_build(30);
         n = 0;
         while (n < 22) begin
            case ($urandom_range(99)) inside
               [0:79]:  send_random_query();
               [80:89]: send_outside_query();
               [90:95]: begin
                  // A broken sequence: a plain load, queries on the stale table, a rebuild.
                  send_request(load_item($urandom_range(grid_rows - 1),
                                         $urandom_range(grid_cols - 1), pick_value(), 1'b0));
                  send_random_query();
                  send_request(load_item($urandom_range(31), $urandom_range(31),
                                         pick_value(), 1'b1));
               end
               default: send_request(load_item($urandom_range(31), $urandom_range(31),
                                               pick_value(), 1'b1));
            endcase
            n++;
         end
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      csr_we         = 1'b0;
      csr_index      = REG_ROWS;
      csr_wdata      = '0;
      mismatches     = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_len       = 0;
      hold_seq       = 0;
      quiet_cycles   = 0;
      grid_rows      = S2RM_MAX_ROWS;
      grid_cols      = S2RM_MAX_COLS;
      grid_built     = 1'b0;
      for (int i = 0; i < S2RM_MAX_ROWS; i++)
         for (int j = 0; j < S2RM_MAX_COLS; j++) begin
            grid_cells[i][j]  = '0;
            cell_loaded[i][j] = 1'b0;
         end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_single_row();
      test_backpressure();
      test_random();
      test_tall_grid();

      wait_drained();
      if (mismatches == 0 && pending_rsp_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
